// ----- rtl/hte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hte_pkg
// Types and constants shared by the HTML text escape encoder modules.
// ----------------------------------------------------------------------------
package hte_pkg;

    // Depth of the queue between the classifier and the run sequencer
    localparam int QUEUE_DEPTH = 4;

    // Width of the byte index within one escaped run (longest run is 32 bytes)
    localparam int IDX_W = 5;

    // Escape run selected for one input byte
    typedef enum logic [2:0] {
        RUN_PASS,
        RUN_LT,
        RUN_GT,
        RUN_AMP,
        RUN_QUOT,
        RUN_APOS,
        RUN_BR,
        RUN_TAB
    } t_run;

    // One classified word handed from front to back
    typedef struct packed {
        t_run       run;
        logic [7:0] ch;
        logic       str_end;
    } t_item;

    // Index of the final byte of each run
    function automatic logic [IDX_W-1:0] run_last_idx(input t_run run);
        logic [IDX_W-1:0] idx;
        idx = '0;
        unique case (run)
            RUN_PASS: idx = IDX_W'(0);
            RUN_LT:   idx = IDX_W'(3);
            RUN_GT:   idx = IDX_W'(3);
            RUN_AMP:  idx = IDX_W'(4);
            RUN_QUOT: idx = IDX_W'(5);
            RUN_APOS: idx = IDX_W'(4);
            RUN_BR:   idx = IDX_W'(4);
            RUN_TAB:  idx = IDX_W'(31);
            default:  idx = IDX_W'(0);
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/html_text_escape_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// html_text_escape_encoder
// HTML escaping of a byte stream for body text or attribute values.
// ----------------------------------------------------------------------------
// Each input byte produces a run of 1 to 32 output bytes: plain bytes pass
// through as one byte, entities give as many bytes as their length (4 to 6,
// or 32 for a tab in text context). The run sequencer emits one output byte
// per cycle while the result register is free or being popped. Input is
// taken every cycle while the queue of QUEUE_DEPTH words ahead of the
// sequencer has room, so long runs stall push only once that queue fills.
// A word passes from the classifier register, which the accepting edge
// loads, into the queue, and from the queue head the sequencer loads its
// bytes into the result register.
// ----------------------------------------------------------------------------
module html_text_escape_encoder #(
    parameter int QUEUE_DEPTH = hte_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_attr_mode,
    input  wire logic       i_string_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_char_out,
    output logic            o_run_last,
    output logic            o_string_done
);
    import hte_pkg::*;

    logic  front_valid;
    t_item front_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  q_rd;

    hte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_in    (i_char_in),
        .i_attr_mode  (i_attr_mode),
        .i_string_end (i_string_end),
        .o_valid      (front_valid),
        .o_item       (front_item),
        .i_q_full     (q_full)
    );

    hte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_rd    (q_rd)
    );

    hte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_rd        (q_rd),
        .empty         (empty),
        .pop           (pop),
        .o_char_out    (o_char_out),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule
`default_nettype wire

// ----- rtl/hte_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hte_front
// Accepts raw bytes, picks the escape run for each and registers the word
// for the queue.
// ----------------------------------------------------------------------------
module hte_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_char_in,
    input  wire logic          i_attr_mode,
    input  wire logic          i_string_end,
    output logic               o_valid,
    output hte_pkg::t_item     o_item,
    input  wire logic          i_q_full
);
    import hte_pkg::*;

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;
    logic  drain;

    always_comb begin
        n_item.ch      = i_char_in;
        n_item.str_end = i_string_end;
        unique case (i_char_in)
            CH_LT:   n_item.run = RUN_LT;
            CH_GT:   n_item.run = RUN_GT;
            CH_AMP:  n_item.run = RUN_AMP;
            CH_NL:   n_item.run = i_attr_mode ? RUN_PASS : RUN_BR;
            CH_TAB:  n_item.run = i_attr_mode ? RUN_PASS : RUN_TAB;
            CH_QUOT: n_item.run = i_attr_mode ? RUN_QUOT : RUN_PASS;
            CH_APOS: n_item.run = i_attr_mode ? RUN_APOS : RUN_PASS;
            default: n_item.run = RUN_PASS;
        endcase
    end

    assign drain  = r_valid && !i_q_full;
    assign full   = r_valid && i_q_full;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

// ----- rtl/hte_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hte_queue
// Small first-in first-out store of classified words between front and back.
// ----------------------------------------------------------------------------
module hte_queue #(
    parameter int DEPTH = hte_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  hte_pkg::t_item     i_item,
    output logic               o_full,
    output logic               o_valid,
    output hte_pkg::t_item     o_item,
    input  wire logic          i_rd
);
    import hte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_FULL) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a write");

endmodule
`default_nettype wire

// ----- rtl/hte_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hte_back
// Run sequencer: walks the escape run of the word at the queue head into
// the result register, one byte a cycle while that register is free or popped.
// ----------------------------------------------------------------------------
module hte_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  hte_pkg::t_item     i_q_item,
    output logic               o_q_rd,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         o_char_out,
    output logic               o_run_last,
    output logic               o_string_done
);
    import hte_pkg::*;

    localparam logic [8*4-1:0]  ENT_LT   = "&lt;";
    localparam logic [8*4-1:0]  ENT_GT   = "&gt;";
    localparam logic [8*5-1:0]  ENT_AMP  = "&amp;";
    localparam logic [8*6-1:0]  ENT_QUOT = "&quot;";
    localparam logic [8*5-1:0]  ENT_APOS = "&#39;";
    localparam logic [8*5-1:0]  ENT_BR   = "<br>\n";
    localparam logic [8*32-1:0] ENT_TAB  = "&nbsp; &nbsp;&nbsp; &nbsp; &nbsp";

    logic             r_out_valid;
    logic [7:0]       r_char;
    logic             r_run_last;
    logic             r_done;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] last_idx;
    logic             at_last;
    logic             advance;
    logic [7:0]       byte_sel;

    // Byte of the current run at position r_idx; strings sit MSB first
    always_comb begin
        byte_sel = i_q_item.ch;
        unique case (i_q_item.run)
            RUN_PASS: byte_sel = i_q_item.ch;
            RUN_LT:   byte_sel = ENT_LT[8*(3 - r_idx[1:0]) +: 8];
            RUN_GT:   byte_sel = ENT_GT[8*(3 - r_idx[1:0]) +: 8];
            RUN_AMP:  byte_sel = (r_idx[2:0] > 3'd4) ? 8'h00
                               : ENT_AMP[8*(4 - r_idx[2:0]) +: 8];
            RUN_QUOT: byte_sel = (r_idx[2:0] > 3'd5) ? 8'h00
                               : ENT_QUOT[8*(5 - r_idx[2:0]) +: 8];
            RUN_APOS: byte_sel = (r_idx[2:0] > 3'd4) ? 8'h00
                               : ENT_APOS[8*(4 - r_idx[2:0]) +: 8];
            RUN_BR:   byte_sel = (r_idx[2:0] > 3'd4) ? 8'h00
                               : ENT_BR[8*(4 - r_idx[2:0]) +: 8];
            RUN_TAB:  byte_sel = ENT_TAB[8*(31 - r_idx) +: 8];
            default:  byte_sel = i_q_item.ch;
        endcase
    end

    assign last_idx = run_last_idx(i_q_item.run);
    assign at_last  = (r_idx == last_idx);
    // Move a byte out when the result register is free or being taken
    assign advance  = i_q_valid && (!r_out_valid || pop);
    assign o_q_rd   = advance && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_last ? '0 : r_idx + 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char     <= byte_sel;
            r_run_last <= at_last;
            r_done     <= at_last && i_q_item.str_end;
        end
    end

    assign empty         = !r_out_valid;
    assign o_char_out    = r_char;
    assign o_run_last    = r_run_last;
    assign o_string_done = r_done;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx <= last_idx))
        else $error("run index past end of run");

    a_idx_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> i_q_valid)
        else $error("run in progress without a queued word");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_run_last)
        else $error("string done flagged before end of run");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !pop) |=> (r_out_valid && $stable(r_char)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- bench/escape_run_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_run_checker
// Watches both queue ports of the HTML escape encoder, works out the escaped
// byte run that each accepted input word must produce, and compares every
// popped word field by field against the oldest byte still due.
// ----------------------------------------------------------------------------
module escape_run_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic       i_full,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_attr_mode,
    input  wire logic       i_string_end,
    input  wire logic       i_empty,
    input  wire logic       i_pop,
    input  wire logic [7:0] i_char_out,
    input  wire logic       i_run_last,
    input  wire logic       i_string_done,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    import hte_pkg::*;

    localparam logic [7:0] CH_LT   = "<";
    localparam logic [7:0] CH_GT   = ">";
    localparam logic [7:0] CH_AMP  = "&";
    localparam logic [7:0] CH_NL   = "\n";
    localparam logic [7:0] CH_TAB  = "\t";
    localparam logic [7:0] CH_QUOT = "\"";
    localparam logic [7:0] CH_APOS = "'";

    // Keep the log short on a badly broken design; counting carries on
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       string_done;
    } t_out_byte;

    t_out_byte escaped_bytes_due[$];
    int        fails = 0;
    int        checked = 0;

    function automatic t_run classify_byte(input logic [7:0] c, input logic attr);
        t_run r;
        r = RUN_PASS;
        case (c)
            CH_LT:   r = RUN_LT;
            CH_GT:   r = RUN_GT;
            CH_AMP:  r = RUN_AMP;
            CH_NL:   if (!attr) r = RUN_BR;
            CH_TAB:  if (!attr) r = RUN_TAB;
            CH_QUOT: if (attr) r = RUN_QUOT;
            CH_APOS: if (attr) r = RUN_APOS;
            default: r = RUN_PASS;
        endcase
        return r;
    endfunction

    function automatic string entity_text(input t_run r);
        case (r)
            RUN_LT:   return "&lt;";
            RUN_GT:   return "&gt;";
            RUN_AMP:  return "&amp;";
            RUN_QUOT: return "&quot;";
            RUN_APOS: return "&#39;";
            RUN_BR:   return "<br>\n";
            RUN_TAB:  return "&nbsp; &nbsp;&nbsp; &nbsp; &nbsp";
            default:  return "";
        endcase
    endfunction

    task automatic predict_escape_run(input logic [7:0] c, input logic attr,
                                      input logic last);
        t_run      r;
        string     txt;
        t_out_byte b;
        r = classify_byte(c, attr);
        txt = entity_text(r);
        if (r == RUN_PASS) begin
            b.ch = c;
            b.run_last = 1'b1;
            b.string_done = last;
            escaped_bytes_due.push_back(b);
        end else begin
            for (int k = 0; k < txt.len(); k++) begin
                b.ch = txt[k];
                b.run_last = (k == txt.len() - 1);
                b.string_done = b.run_last && last;
                escaped_bytes_due.push_back(b);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (fails < MAX_REPORTS)
            $display("[%0t] mismatch on byte %0d: %s got %02h want %02h",
                     $realtime, checked, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_out_byte want;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                if (escaped_bytes_due.size() == 0) begin
                    report_mismatch("word with nothing due, char_out", i_char_out, 8'h00);
                end else begin
                    want = escaped_bytes_due.pop_front();
                    if (i_char_out !== want.ch)
                        report_mismatch("char_out", i_char_out, want.ch);
                    if (i_run_last !== want.run_last)
                        report_mismatch("run_last", 8'(i_run_last), 8'(want.run_last));
                    if (i_string_done !== want.string_done)
                        report_mismatch("string_done", 8'(i_string_done),
                                        8'(want.string_done));
                    checked++;
                end
            end
            if (i_push && !i_full)
                predict_escape_run(i_char_in, i_attr_mode, i_string_end);
        end
        o_pending    <= escaped_bytes_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule
`default_nettype wire

// ----- bench/tb_html_text_escape_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_html_text_escape_encoder
// Drives the HTML escape encoder with a directed sweep of every escaped
// character in both contexts, then random strings, with random gaps on both
// queue ports; a separate checker predicts and compares the output bytes.
// ----------------------------------------------------------------------------
module tb_html_text_escape_encoder;

    localparam int ITEMS        = 310;
    localparam int LIMIT        = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_SPECIAL    = 8;

    localparam logic [7:0] CH_TAB = "\t";
    localparam logic [7:0] SPECIAL_CHARS [N_SPECIAL] =
        '{"<", ">", "&", "\n", "\t", "\"", "'", " "};

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_char_in;
    logic       i_attr_mode;
    logic       i_string_end;
    logic       empty;
    logic       pop;
    logic [7:0] o_char_out;
    logic       o_run_last;
    logic       o_string_done;

    int  fail_count;
    int  bytes_pending;
    int  bytes_checked;
    int  words_sent = 0;
    int  tabs_sent = 0;
    int  strings_sent = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    html_text_escape_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_char_in    (i_char_in),
        .i_attr_mode  (i_attr_mode),
        .i_string_end (i_string_end),
        .empty        (empty),
        .pop          (pop),
        .o_char_out   (o_char_out),
        .o_run_last   (o_run_last),
        .o_string_done(o_string_done)
    );

    escape_run_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_char_in    (i_char_in),
        .i_attr_mode  (i_attr_mode),
        .i_string_end (i_string_end),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_char_out   (o_char_out),
        .i_run_last   (o_run_last),
        .i_string_done(o_string_done),
        .o_fail_count (fail_count),
        .o_pending    (bytes_pending),
        .o_checked    (bytes_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycles, bytes_pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 45)
            return SPECIAL_CHARS[$urandom_range(N_SPECIAL - 1)];
        return 8'($urandom_range(255));
    endfunction

    // Result side: hold pop low for random stretches
    initial begin
        int hold;
        hold = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    task automatic send_word(input logic [7:0] c, input logic attr, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push         <= 1'b1;
        i_char_in    <= c;
        i_attr_mode  <= attr;
        i_string_end <= last;
        do @(posedge i_clk); while (full);
        words_sent++;
        if (c == CH_TAB && !attr)
            tabs_sent++;
    endtask

    // Noisy strings flip context and end flags at random within the string
    task automatic send_string(input int len, input logic attr, input bit noisy);
        logic a;
        logic e;
        for (int k = 0; k < len; k++) begin
            a = noisy ? 1'($urandom_range(1)) : attr;
            e = noisy ? 1'($urandom_range(1)) : (k == len - 1);
            send_word(pick_char(), a, e);
        end
        strings_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        do @(posedge i_clk); while (bytes_pending != 0);
    endtask

    initial begin
        bit paused;
        paused       = 1'b0;
        push         = 1'b0;
        i_char_in    = 8'h00;
        i_attr_mode  = 1'b0;
        i_string_end = 1'b0;
        i_rst_n      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every escaped character and the byte extremes, in both contexts
        for (int mode = 0; mode < 2; mode++) begin
            for (int k = 0; k < N_SPECIAL; k++)
                send_word(SPECIAL_CHARS[k], 1'(mode), 1'(k % 2));
            send_word(8'h00, 1'(mode), 1'b0);
            send_word(8'hFF, 1'(mode), 1'b1);
        end
        strings_sent += 2;
        wait_drained();

        while (words_sent < ITEMS) begin
            calm = ($urandom_range(99) < 15);
            send_string($urandom_range(1, 10), 1'($urandom_range(1)),
                        $urandom_range(99) < 15);
            // hold off once mid-run until the encoder has fully drained
            if (!paused && words_sent > 170) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d input words in %0d strings, %0d of them text-context tabs",
                 words_sent, strings_sent, tabs_sent);
        $display("checked %0d escaped output bytes, %0d mismatches", bytes_checked, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
